@@ rtl/load_constant_sequence_gen_macros.svh @@
// Assertion macros for the load constant sequence generator checker.
// Used by lcsg_checker.sv; expects clk and rst_n in the enclosing scope.
`ifndef LOAD_CONSTANT_SEQUENCE_GEN_MACROS_SVH
`define LOAD_CONSTANT_SEQUENCE_GEN_MACROS_SVH

// same-cycle implication
`define LCSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lcsg_pkg.sv @@
// Shared types and constants of the load constant sequence generator.
// No dependencies; imported by every module of the block.
package lcsg_pkg;

  localparam int VAL_W       = 64;
  localparam int IMM_W       = 20;
  localparam int WORD_BITS   = 32;
  localparam int HI20_SHIFT  = 44;
  localparam int CNT_W       = 7;
  localparam int CHUNK11_W   = 11;
  localparam int CHUNK10_W   = 10;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADDI  = 3'd0,
    OP_LUI   = 3'd1,
    OP_ADDIW = 3'd2,
    OP_SLLI  = 3'd3,
    OP_SRLI  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CLS_ZERO     = 3'd0,
    CLS_SIMM12   = 3'd1,
    CLS_SIMM32   = 3'd2,
    CLS_SHIFTED  = 3'd3,
    CLS_FALLBACK = 3'd4
  } cls_t;

  // compact form of one constant's instruction sequence
  typedef struct packed {
    cls_t        cls;
    logic [19:0] hi20;
    logic [11:0] lo12;
    logic [6:0]  tz;
    logic [31:0] low_word;
  } desc_t;

endpackage

@@ rtl/load_constant_sequence_gen.sv @@
// Top level of the RV64 load constant sequence generator.
// Depends on lcsg_pkg, lcsg_front, lcsg_queue and lcsg_back.
//
//   channel  | ports                         | transaction when
//   ---------+-------------------------------+---------------------
//   input    | push, full, in_constant_value | push && !full
//   result   | empty, pop, out_*             | pop && !empty
//
// One instruction leaves per cycle while results are popped; a constant
// takes 1, 2, 3, 4 or 8 instructions by class, 8 at worst.
// The first instruction passes the input register, the queue and then the
// output register. Synchronous reset empties all.
// A stalled result holds; the queue lets the front keep taking items.
module load_constant_sequence_gen import lcsg_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [63:0] in_constant_value,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_opcode_kind,
  output logic signed [19:0] out_immediate,
  output logic [2:0]         out_pattern_class,
  output logic               out_last
);

  logic  q_push, q_full, q_pop, q_valid;
  desc_t q_wdata, q_rdata;

  lcsg_front u_front (
    .clk,
    .rst_n,
    .push,
    .full,
    .in_constant_value,
    .q_full,
    .q_push,
    .q_desc (q_wdata)
  );

  lcsg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk,
    .rst_n,
    .q_push,
    .q_wdata,
    .q_full,
    .q_pop,
    .q_valid,
    .q_rdata
  );

  lcsg_back u_back (
    .clk,
    .rst_n,
    .q_valid,
    .q_desc (q_rdata),
    .q_pop,
    .empty,
    .pop,
    .out_opcode_kind,
    .out_immediate,
    .out_pattern_class,
    .out_last
  );

endmodule

@@ rtl/lcsg_front.sv @@
// Front end: input register, zero counts, classification into a descriptor.
// Depends on lcsg_pkg; feeds lcsg_queue.
module lcsg_front import lcsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [63:0] in_constant_value,
  input  logic               q_full,
  output logic               q_push,
  output desc_t              q_desc
);

  logic        a_valid_r, a_valid_nxt;
  logic [63:0] a_value_r;
  logic [6:0]  a_lz_r, a_tz_r;
  logic        accept;
  logic [63:0] v, shifted;
  logic [31:0] src_word;
  logic [7:0]  zsum;
  cls_t        cls;

  function automatic logic [6:0] clz64(logic [63:0] val);
    logic [63:0] x;
    logic [6:0]  n;
    x = val;
    n = '0;
    for (int s = 5; s >= 0; s--) begin
      if ((x >> (VAL_W - (1 << s))) == 64'd0) begin
        n = n + 7'(1 << s);
        x = x << (1 << s);
      end
    end
    if (val == 64'd0) begin
      n = 7'(VAL_W);
    end
    return n;
  endfunction

  function automatic logic [6:0] ctz64(logic [63:0] val);
    logic [63:0] x;
    logic [6:0]  n;
    x = val;
    n = '0;
    for (int s = 5; s >= 0; s--) begin
      if ((x & ((64'd1 << (1 << s)) - 64'd1)) == 64'd0) begin
        n = n + 7'(1 << s);
        x = x >> (1 << s);
      end
    end
    if (val == 64'd0) begin
      n = 7'(VAL_W);
    end
    return n;
  endfunction

  assign full   = a_valid_r && q_full;
  assign accept = push && !full;
  assign q_push = a_valid_r && !q_full;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_value_r <= in_constant_value;
      a_lz_r    <= clz64(in_constant_value);
      a_tz_r    <= ctz64(in_constant_value);
    end
  end

  always_comb begin
    v       = a_value_r;
    zsum    = {1'b0, a_lz_r} + {1'b0, a_tz_r};
    shifted = v >> a_tz_r;
    if (v == 64'd0) begin
      cls = CLS_ZERO;
    end else if ((&v[63:11]) || !(|v[63:11])) begin
      cls = CLS_SIMM12;
    end else if ((&v[63:31]) || !(|v[63:31])) begin
      cls = CLS_SIMM32;
    end else if (zsum >= 8'(WORD_BITS)) begin
      cls = CLS_SHIFTED;
    end else begin
      cls = CLS_FALLBACK;
    end

    case (cls)
      CLS_FALLBACK: src_word = v[HI20_SHIFT+19 -: 32];
      CLS_SHIFTED:  src_word = shifted[31:0];
      default:      src_word = v[31:0];
    endcase

    q_desc.cls      = cls;
    q_desc.hi20     = src_word[31:12] + 20'(src_word[11]);
    q_desc.lo12     = src_word[11:0];
    q_desc.tz       = a_tz_r;
    q_desc.low_word = v[31:0];
  end

endmodule

@@ rtl/lcsg_queue.sv @@
// Short descriptor queue between the front end and the sequencer.
// Depends on lcsg_pkg for desc_t.
module lcsg_queue import lcsg_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_push,
  input  desc_t q_wdata,
  output logic  q_full,
  input  logic  q_pop,
  output logic  q_valid,
  output desc_t q_rdata
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t            mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign q_full  = count_r == CntW'(Depth);
  assign q_valid = count_r != '0;
  assign q_rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

@@ rtl/lcsg_back.sv @@
// Back end: steps through one descriptor into the output register, one
// instruction per cycle unless a stalled result holds it. Depends on lcsg_pkg; reads lcsg_queue.
module lcsg_back import lcsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  desc_t              q_desc,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_opcode_kind,
  output logic signed [19:0] out_immediate,
  output logic [2:0]         out_pattern_class,
  output logic               out_last
);

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  step_r, step_nxt;
  op_t         op_r;
  logic [19:0] imm_r;
  cls_t        cls_r;
  logic        last_r;
  logic        adv, load, last;
  logic [3:0]  len;
  op_t         op;
  logic [19:0] imm, lo12_sx;
  logic        big_shift;

  assign adv     = !out_valid_r || pop;
  assign load    = adv && q_valid;
  assign q_pop   = load && last;
  assign lo12_sx = {{8{q_desc.lo12[11]}}, q_desc.lo12};
  assign big_shift = q_desc.tz >= 7'(WORD_BITS);

  always_comb begin
    unique case (q_desc.cls)
      CLS_ZERO, CLS_SIMM12: len = 4'd1;
      CLS_SIMM32:           len = 4'd2;
      CLS_SHIFTED:          len = big_shift ? 4'd3 : 4'd4;
      CLS_FALLBACK:         len = 4'd8;
      default:              len = 4'd8;
    endcase
    last = ({1'b0, step_r} + 4'd1) == len;

    op  = OP_ADDI;
    imm = lo12_sx;
    unique case (q_desc.cls)
      CLS_ZERO, CLS_SIMM12: begin
        op  = OP_ADDI;
        imm = lo12_sx;
      end
      CLS_SIMM32, CLS_SHIFTED: begin
        unique case (step_r)
          3'd0: begin
            op  = OP_LUI;
            imm = q_desc.hi20;
          end
          3'd1: begin
            op  = OP_ADDIW;
            imm = lo12_sx;
          end
          3'd2: begin
            op  = OP_SLLI;
            imm = big_shift ? 20'(q_desc.tz) : 20'(WORD_BITS);
          end
          default: begin
            op  = OP_SRLI;
            imm = 20'(WORD_BITS) - 20'(q_desc.tz);
          end
        endcase
      end
      CLS_FALLBACK: begin
        unique case (step_r)
          3'd0: begin
            op  = OP_LUI;
            imm = q_desc.hi20;
          end
          3'd1: begin
            op  = OP_ADDIW;
            imm = lo12_sx;
          end
          3'd2, 3'd4: begin
            op  = OP_SLLI;
            imm = 20'(CHUNK11_W);
          end
          3'd3: begin
            op  = OP_ADDI;
            imm = 20'(q_desc.low_word[31:21]);
          end
          3'd5: begin
            op  = OP_ADDI;
            imm = 20'(q_desc.low_word[20:10]);
          end
          3'd6: begin
            op  = OP_SLLI;
            imm = 20'(CHUNK10_W);
          end
          default: begin
            op  = OP_ADDI;
            imm = 20'(q_desc.low_word[9:0]);
          end
        endcase
      end
      default: begin
        op  = OP_ADDI;
        imm = lo12_sx;
      end
    endcase

    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = last ? 3'd0 : step_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= op;
      imm_r  <= imm;
      cls_r  <= q_desc.cls;
      last_r <= last;
    end
  end

  assign empty             = !out_valid_r;
  assign out_opcode_kind   = op_r;
  assign out_immediate     = imm_r;
  assign out_pattern_class = cls_r;
  assign out_last          = last_r;

endmodule

@@ rtl/lcsg_checker.sv @@
// Port-level checks of load_constant_sequence_gen, bound to the top level.
// Depends on lcsg_pkg and load_constant_sequence_gen_macros.svh.
`include "load_constant_sequence_gen_macros.svh"

module lcsg_checker import lcsg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input logic signed [63:0] in_constant_value,
  input logic               empty,
  input logic               pop,
  input logic [2:0]         out_opcode_kind,
  input logic signed [19:0] out_immediate,
  input logic [2:0]         out_pattern_class,
  input logic               out_last
);

  `LCSG_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(out_opcode_kind) && $stable(out_immediate) && $stable(out_pattern_class) && $stable(out_last), "result changed while stalled")
  `LCSG_ASSERT_NEXT(a_seq_continues, !empty && pop && !out_last, !empty && $stable(out_pattern_class), "sequence broken before last")
  `LCSG_ASSERT_IMP(a_single_last, !empty && (out_pattern_class == CLS_ZERO || out_pattern_class == CLS_SIMM12), out_last, "single-instruction class without last")
  `LCSG_ASSERT_NEXT(a_lui_addiw, !empty && pop && out_opcode_kind == OP_LUI, !empty && out_opcode_kind == OP_ADDIW, "lui not followed by addiw")

endmodule

bind load_constant_sequence_gen lcsg_checker u_lcsg_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for load_constant_sequence_gen: directed constants, then random ones
// under several push/pop idling mixes, each instruction checked against a typed row or a local predictor.
// Depends on lcsg_pkg and the load_constant_sequence_gen RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcsg_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int ITEMS_PER_MIX = 120;
  localparam int NUM_MIXES     = 4;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_DIRECTED  = 21;

  typedef struct packed {
    op_t         op;
    logic [19:0] imm;
    cls_t        cls;
    logic        last;
  } insn_t;

  typedef struct packed {
    logic [63:0] val;
    logic        typed;
    op_t         op;
    logic [19:0] imm;
    cls_t        cls;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic signed [63:0] in_constant_value;
  logic               empty;
  logic               pop = 1'b0;
  logic [2:0]         out_opcode_kind;
  logic signed [19:0] out_immediate;
  logic [2:0]         out_pattern_class;
  logic               out_last;

  insn_t insn_expected[$];
  int    send_idle_pct;
  int    recv_stall_pct;
  int    errors;
  int    insn_checked;
  int    constants_sent;
  int    class_count[5];
  int    quiet_cycles;

  int send_idle_mix[NUM_MIXES]  = '{0, 57, 0, 14};
  int recv_stall_mix[NUM_MIXES] = '{0, 0, 57, 14};

  // typed rows carry the single expected instruction; the rest go through the predictor
  directed_row_t directed_rows[NUM_DIRECTED] = '{
    '{64'h0000_0000_0000_0000, 1'b1, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0000_0000_0001, 1'b1, OP_ADDI, 20'h00001, CLS_SIMM12},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, OP_ADDI, 20'hFFFFF, CLS_SIMM12},
    '{64'h0000_0000_0000_07FF, 1'b1, OP_ADDI, 20'h007FF, CLS_SIMM12},
    '{64'hFFFF_FFFF_FFFF_F800, 1'b1, OP_ADDI, 20'hFF800, CLS_SIMM12},
    '{64'h0000_0000_0000_0800, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'hFFFF_FFFF_FFFF_F7FF, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0000_7FFF_FFFF, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'hFFFF_FFFF_8000_0000, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0000_1234_5678, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0000_8000_0000, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0001_0000_0000, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h8000_0000_0000_0000, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h0000_0FFF_FFFF_F000, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'hFFFF_FFFF_0000_0000, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h1234_5678_9ABC_DEF0, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h5555_5555_5555_5555, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO},
    '{64'h7FFF_F800_0000_0001, 1'b0, OP_ADDI, 20'h00000, CLS_ZERO}
  };

  load_constant_sequence_gen dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_constant_value (in_constant_value),
    .empty             (empty),
    .pop               (pop),
    .out_opcode_kind   (out_opcode_kind),
    .out_immediate     (out_immediate),
    .out_pattern_class (out_pattern_class),
    .out_last          (out_last)
  );

  always #CLK_HALF clk = ~clk;

  // appends the instruction sequence that materializes v
  function automatic void expand_constant(input logic [63:0] v);
    insn_t       seq[$];
    logic [63:0] shifted;
    logic [31:0] word;
    logic [19:0] hi20;
    cls_t        cls;
    int          lz;
    int          tz;
    lz = 0;
    tz = 0;
    if (v == 64'd0) begin
      seq.push_back('{op: OP_ADDI, imm: 20'd0, cls: CLS_ZERO, last: 1'b0});
    end else if (v[63:11] == '0 || v[63:11] == '1) begin
      seq.push_back('{op: OP_ADDI, imm: v[19:0], cls: CLS_SIMM12, last: 1'b0});
    end else begin
      while (lz < 64 && !v[63 - lz]) lz++;
      while (tz < 64 && !v[tz]) tz++;
      if (v[63:31] == '0 || v[63:31] == '1 || lz + tz >= WORD_BITS) begin
        if (v[63:31] == '0 || v[63:31] == '1) begin
          cls = CLS_SIMM32;
          word = v[31:0];
        end else begin
          cls = CLS_SHIFTED;
          shifted = v >> tz;
          word = shifted[31:0];
        end
        hi20 = word[31:12] + {19'd0, word[11]};
        seq.push_back('{op: OP_LUI, imm: hi20, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_ADDIW, imm: {{8{word[11]}}, word[11:0]}, cls: cls, last: 1'b0});
        if (cls == CLS_SHIFTED) begin
          if (tz >= WORD_BITS) begin
            seq.push_back('{op: OP_SLLI, imm: 20'(tz), cls: cls, last: 1'b0});
          end else begin
            seq.push_back('{op: OP_SLLI, imm: 20'(WORD_BITS), cls: cls, last: 1'b0});
            seq.push_back('{op: OP_SRLI, imm: 20'(WORD_BITS - tz), cls: cls, last: 1'b0});
          end
        end
      end else begin
        cls = CLS_FALLBACK;
        hi20 = v[63:44] + {19'd0, v[43]};
        seq.push_back('{op: OP_LUI, imm: hi20, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_ADDIW, imm: {{8{v[43]}}, v[43:32]}, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_SLLI, imm: 20'd11, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_ADDI, imm: {9'd0, v[31:21]}, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_SLLI, imm: 20'd11, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_ADDI, imm: {9'd0, v[20:10]}, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_SLLI, imm: 20'd10, cls: cls, last: 1'b0});
        seq.push_back('{op: OP_ADDI, imm: {10'd0, v[9:0]}, cls: cls, last: 1'b0});
      end
    end
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) insn_expected.push_back(seq[i]);
  endfunction

  // mostly class-targeted constants, plus full random words and boundary patterns
  function automatic logic [63:0] random_constant();
    logic [63:0] r;
    logic [63:0] chunk;
    logic [63:0] bound;
    int          width;
    int          sh;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return ($urandom_range(3) == 0) ? 64'd0 : {{52{r[11]}}, r[11:0]};
      1: return {{52{r[11]}}, r[11:0]};
      2, 3: return {{32{r[31]}}, r[31:0]};
      4, 5: begin
        width = $urandom_range(1, 32);
        chunk = r & ((64'd1 << width) - 64'd1);
        chunk[0] = 1'b1;
        sh = $urandom_range(0, 64 - width);
        return chunk << sh;
      end
      9: begin
        bound = 64'd1 << ($urandom_range(1) ? 11 : 31);
        case ($urandom_range(2))
          0: return 64'd1 << $urandom_range(63);
          1: return ~(64'd1 << $urandom_range(63));
          default: return ($urandom_range(1) ? bound : -bound) + 64'($urandom_range(2)) - 64'd1;
        endcase
      end
      default: return r;
    endcase
  endfunction

  task automatic send_constant(input directed_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_constant_value <= row.val;
    do @(posedge clk); while (full);
    if (row.typed) begin
      insn_expected.push_back('{op: row.op, imm: row.imm, cls: row.cls, last: 1'b1});
    end else begin
      expand_constant(row.val);
    end
    constants_sent++;
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input logic [19:0] want,
                                      input logic [19:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    insn_t want;
    if (rst_n && pop && !empty) begin
      if (insn_expected.size() == 0) begin
        $display("%0t: unexpected instruction, expected none actual op %0d imm 0x%0h",
                 $time, out_opcode_kind, out_immediate);
        errors++;
      end else begin
        want = insn_expected.pop_front();
        check_field("opcode_kind", 20'(want.op), 20'(out_opcode_kind));
        check_field("immediate", want.imm, out_immediate);
        check_field("pattern_class", 20'(want.cls), 20'(out_pattern_class));
        check_field("last", 20'(want.last), 20'(out_last));
        insn_checked++;
        if (want.last) class_count[want.cls]++;
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d instructions outstanding",
               $time, STALL_LIMIT, insn_expected.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    rst_n = 1'b0;
    push = 1'b0;
    in_constant_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    insn_checked = 0;
    constants_sent = 0;
    quiet_cycles = 0;
    foreach (class_count[i]) class_count[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_constant(directed_rows[i]);

    for (int mix = 0; mix < NUM_MIXES; mix++) begin
      send_idle_pct = send_idle_mix[mix];
      recv_stall_pct = recv_stall_mix[mix];
      repeat (ITEMS_PER_MIX) begin
        row = '{val: random_constant(), typed: 1'b0, op: OP_ADDI, imm: 20'd0, cls: CLS_ZERO};
        send_constant(row);
      end
    end
    push <= 1'b0;
    recv_stall_pct = 0;

    while (insn_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d constants (%0d directed) expanded into %0d checked instructions",
             constants_sent, NUM_DIRECTED, insn_checked);
    $display("sequences by class: zero %0d, simm12 %0d, simm32 %0d, shifted %0d, fallback %0d",
             class_count[CLS_ZERO], class_count[CLS_SIMM12], class_count[CLS_SIMM32],
             class_count[CLS_SHIFTED], class_count[CLS_FALLBACK]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lcsg_pkg.sv
rtl/lcsg_front.sv
rtl/lcsg_queue.sv
rtl/lcsg_back.sv
rtl/load_constant_sequence_gen.sv
rtl/lcsg_checker.sv
verif/tb_top.sv
